>>> design/bba_pkg.sv
`default_nettype none
package bba_pkg;
	localparam int LOG_UNITS  = 10;
	localparam int MEM_UNITS  = 1 << LOG_UNITS;
	localparam int MIN_BLOCK  = 1;
	localparam int NODE_COUNT = 2 * MEM_UNITS - 1;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int SIZE_W     = LOG_UNITS + 1;
	localparam int DEPTH_W    = $clog2(LOG_UNITS + 1);
	localparam int OWNER_W    = 16;
	localparam int REQ_W      = 11;
	localparam int ADDR_W     = 10;

	typedef enum logic [1:0] {
		KIND_ABSENT = 2'd0,
		KIND_FREE   = 2'd1,
		KIND_USED   = 2'd2,
		KIND_SPLIT  = 2'd3
	} kind_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_SPLIT,
		ST_SPLIT_R,
		ST_SPLIT_L,
		ST_FREE_W,
		ST_MERGE_RD,
		ST_MERGE_CHK,
		ST_MERGE_B,
		ST_MERGE_C
	} state_t;
endpackage
`default_nettype wire

>>> design/bba_ram.sv
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2047,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> design/buddy_block_allocator.sv
// A transaction scans all 2047 tree nodes, one per cycle, then decides in ST_DECIDE.
// If a block was found, an allocate then splits it level by level (split mark, right child,
// left child), and a free marks it free and merges level by level (read buddy, check, clear both, free parent).
// done is high for one cycle after that, with busy already low; a new transaction is taken
// only while busy is low, so never before the last one has finished; the receiver cannot stall.
// After reset a clearing pass initializes all 2047 nodes of the node memory, busy high.
`default_nettype none
module buddy_block_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [10:0] request_size,
	input  wire logic [15:0] owner_id,
	output logic             done,
	output logic             ok,
	output logic [9:0]       start_addr,
	output logic [9:0]       end_addr
);
	localparam int IW = bba_pkg::IDX_W;
	localparam int DW = bba_pkg::DEPTH_W;
	localparam int LW = bba_pkg::LOG_UNITS;
	localparam int SW = bba_pkg::SIZE_W;

	bba_pkg::state_t state_q, state_d;

	logic [IW-1:0] clr_q, scan_q, cur_q, sib_q, best_idx_q, idx_s1;
	logic [DW-1:0] depth_q, cur_depth_q, best_depth_q, depth_s1;
	logic [LW-1:0] pos_q, best_start_q, start_s1;
	logic          valid_s1, found_q;
	logic          op_q;
	logic [bba_pkg::REQ_W-1:0]   req_q;
	logic [bba_pkg::OWNER_W-1:0] owner_q;
	logic          done_q, ok_q;
	logic [bba_pkg::ADDR_W-1:0] sa_q, ea_q;

	logic          kind_we, own_we;
	logic [IW-1:0] kind_wa, rd_addr;
	bba_pkg::kind_t kind_wd;
	logic [1:0]    kind_rd;
	logic [bba_pkg::OWNER_W-1:0] own_rd;

	logic [SW-1:0] size_s1, best_size, cur_size, cur_half;
	logic          split_ok, hit_s1, last_scan;
	logic [IW:0]   child_l, child_r;
	logic [IW-1:0] parent;

	bba_ram #(.WIDTH(2), .DEPTH(bba_pkg::NODE_COUNT)) u_kind (
		.clk(clk), .we(kind_we), .waddr(kind_wa), .wdata(kind_wd),
		.raddr(rd_addr), .rdata(kind_rd)
	);

	bba_ram #(.WIDTH(bba_pkg::OWNER_W), .DEPTH(bba_pkg::NODE_COUNT)) u_owner (
		.clk(clk), .we(own_we), .waddr(kind_wa), .wdata(owner_q),
		.raddr(rd_addr), .rdata(own_rd)
	);

	assign size_s1   = SW'(bba_pkg::MEM_UNITS) >> depth_s1;
	assign best_size = SW'(bba_pkg::MEM_UNITS) >> best_depth_q;
	assign cur_size  = SW'(bba_pkg::MEM_UNITS) >> cur_depth_q;
	assign cur_half  = cur_size >> 1;
	assign split_ok  = (cur_depth_q < DW'(LW)) && (cur_half >= SW'(req_q))
		&& (cur_half >= SW'(bba_pkg::MIN_BLOCK));
	assign child_l   = {cur_q, 1'b0} + (IW+1)'(1);
	assign child_r   = {cur_q, 1'b0} + (IW+1)'(2);
	assign parent    = (cur_q - IW'(1)) >> 1;
	assign last_scan = (scan_q == IW'(bba_pkg::NODE_COUNT - 1));

	always_comb begin
		hit_s1 = 1'b0;
		if (op_q == bba_pkg::OP_ALLOC) begin
			hit_s1 = (kind_rd == bba_pkg::KIND_FREE) && (req_q != '0)
				&& (size_s1 >= SW'(req_q)) && (!found_q || size_s1 < best_size);
		end else begin
			hit_s1 = (kind_rd == bba_pkg::KIND_USED) && (own_rd == owner_q)
				&& (!found_q || start_s1 < best_start_q);
		end
	end

	always_comb begin
		state_d = state_q;
		kind_we = 1'b0;
		own_we  = 1'b0;
		kind_wa = cur_q;
		kind_wd = bba_pkg::KIND_ABSENT;
		rd_addr = scan_q;
		unique case (state_q)
			bba_pkg::ST_CLEAR: begin
				kind_we = 1'b1;
				kind_wa = clr_q;
				kind_wd = (clr_q == '0) ? bba_pkg::KIND_FREE : bba_pkg::KIND_ABSENT;
				if (clr_q == IW'(bba_pkg::NODE_COUNT - 1)) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			bba_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bba_pkg::ST_SCAN;
				end
			end
			bba_pkg::ST_SCAN: begin
				if (last_scan) begin
					state_d = bba_pkg::ST_SCAN_END;
				end
			end
			bba_pkg::ST_SCAN_END: state_d = bba_pkg::ST_DECIDE;
			bba_pkg::ST_DECIDE: begin
				if (!found_q) begin
					state_d = bba_pkg::ST_IDLE;
				end else if (op_q == bba_pkg::OP_ALLOC) begin
					state_d = bba_pkg::ST_SPLIT;
				end else begin
					state_d = bba_pkg::ST_FREE_W;
				end
			end
			bba_pkg::ST_SPLIT: begin
				kind_we = 1'b1;
				if (split_ok) begin
					kind_wd = bba_pkg::KIND_SPLIT;
					state_d = bba_pkg::ST_SPLIT_R;
				end else begin
					kind_wd = bba_pkg::KIND_USED;
					own_we  = 1'b1;
					state_d = bba_pkg::ST_IDLE;
				end
			end
			bba_pkg::ST_SPLIT_R: begin
				kind_we = 1'b1;
				kind_wa = IW'(child_r);
				kind_wd = bba_pkg::KIND_FREE;
				state_d = bba_pkg::ST_SPLIT_L;
			end
			bba_pkg::ST_SPLIT_L: begin
				kind_we = 1'b1;
				kind_wa = IW'(child_l);
				kind_wd = bba_pkg::KIND_FREE;
				state_d = bba_pkg::ST_SPLIT;
			end
			bba_pkg::ST_FREE_W: begin
				kind_we = 1'b1;
				kind_wd = bba_pkg::KIND_FREE;
				state_d = bba_pkg::ST_MERGE_RD;
			end
			bba_pkg::ST_MERGE_RD: begin
				rd_addr = cur_q[0] ? cur_q + IW'(1) : cur_q - IW'(1);
				state_d = (cur_q == '0) ? bba_pkg::ST_IDLE : bba_pkg::ST_MERGE_CHK;
			end
			bba_pkg::ST_MERGE_CHK: begin
				if (kind_rd == bba_pkg::KIND_FREE) begin
					kind_we = 1'b1;
					state_d = bba_pkg::ST_MERGE_B;
				end else begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			bba_pkg::ST_MERGE_B: begin
				kind_we = 1'b1;
				kind_wa = sib_q;
				state_d = bba_pkg::ST_MERGE_C;
			end
			bba_pkg::ST_MERGE_C: begin
				kind_we = 1'b1;
				kind_wa = parent;
				kind_wd = bba_pkg::KIND_FREE;
				state_d = bba_pkg::ST_MERGE_RD;
			end
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bba_pkg::ST_CLEAR;
			clr_q    <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == bba_pkg::ST_SCAN);
			done_q   <= 1'b0;
			if (state_q == bba_pkg::ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (state_q == bba_pkg::ST_DECIDE && !found_q) begin
				done_q <= 1'b1;
			end
			if (state_q == bba_pkg::ST_SPLIT && !split_ok) begin
				done_q <= 1'b1;
			end
			if ((state_q == bba_pkg::ST_MERGE_RD && cur_q == '0)
				|| (state_q == bba_pkg::ST_MERGE_CHK && kind_rd != bba_pkg::KIND_FREE)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= scan_q;
		depth_s1 <= depth_q;
		start_s1 <= LW'(pos_q << (DW'(LW) - depth_q));
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				op_q    <= op;
				req_q   <= request_size;
				owner_q <= owner_id;
				scan_q  <= '0;
				depth_q <= '0;
				pos_q   <= '0;
				found_q <= 1'b0;
			end
			bba_pkg::ST_SCAN: begin
				scan_q <= scan_q + IW'(1);
				if (pos_q == LW'((SW'(1) << depth_q) - SW'(1))) begin
					depth_q <= depth_q + DW'(1);
					pos_q   <= '0;
				end else begin
					pos_q <= pos_q + LW'(1);
				end
			end
			bba_pkg::ST_DECIDE: begin
				cur_q       <= best_idx_q;
				cur_depth_q <= best_depth_q;
				ok_q        <= 1'b0;
				sa_q        <= '0;
				ea_q        <= '0;
			end
			bba_pkg::ST_SPLIT: begin
				if (!split_ok) begin
					ok_q <= 1'b1;
					sa_q <= best_start_q;
					ea_q <= bba_pkg::ADDR_W'(SW'(best_start_q) + cur_size - SW'(1));
				end
			end
			bba_pkg::ST_SPLIT_L: begin
				cur_q       <= IW'(child_l);
				cur_depth_q <= cur_depth_q + DW'(1);
			end
			bba_pkg::ST_MERGE_RD: begin
				sib_q <= rd_addr;
				if (cur_q == '0) begin
					ok_q <= 1'b1;
				end
			end
			bba_pkg::ST_MERGE_CHK: begin
				if (kind_rd != bba_pkg::KIND_FREE) begin
					ok_q <= 1'b1;
				end
			end
			bba_pkg::ST_MERGE_C: cur_q <= parent;
			default: ;
		endcase
		if (valid_s1 && hit_s1) begin
			found_q      <= 1'b1;
			best_idx_q   <= idx_s1;
			best_depth_q <= depth_s1;
			best_start_q <= start_s1;
		end
	end

	assign busy       = (state_q != bba_pkg::ST_IDLE);
	assign done       = done_q;
	assign ok         = ok_q;
	assign start_addr = sa_q;
	assign end_addr   = ea_q;
endmodule
`default_nettype wire

>>> verif/buddy_block_allocator_test.sv
`default_nettype none
module buddy_block_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 60000;
	localparam int RANDOM_ITEMS = 880;
	localparam int CALM_TAIL = 100;

	typedef struct {
		bba_pkg::op_t                op;
		logic [bba_pkg::REQ_W-1:0]   size;
		logic [bba_pkg::OWNER_W-1:0] owner;
		bit                          drain;
	} request_t;

	typedef struct {
		logic                       ok;
		logic [bba_pkg::ADDR_W-1:0] sa;
		logic [bba_pkg::ADDR_W-1:0] ea;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic op = 1'b0;
	logic [bba_pkg::REQ_W-1:0] request_size = '0;
	logic [bba_pkg::OWNER_W-1:0] owner_id = '0;
	wire busy, done, ok;
	wire [bba_pkg::ADDR_W-1:0] start_addr, end_addr;

	buddy_block_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.request_size(request_size), .owner_id(owner_id), .done(done), .ok(ok),
		.start_addr(start_addr), .end_addr(end_addr)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bba_pkg::kind_t tree_kind [bba_pkg::NODE_COUNT];
	logic [bba_pkg::OWNER_W-1:0] tree_owner [bba_pkg::NODE_COUNT];
	request_t pending [$];
	grant_t grants_due [$];
	request_t held;
	int gap = 0;
	int total_items = 0;
	int issued = 0;
	int mismatches = 0;
	int allocs_placed = 0;
	int frees_done = 0;
	int refusals = 0;
	int results_seen = 0;
	int watchdog = 0;
	logic [bba_pkg::OWNER_W-1:0] owner_pool [16];

	function automatic int level_of(int idx);
		int d = 0;
		int v = idx + 1;
		while (v > 1) begin
			v = v >> 1;
			d++;
		end
		return d;
	endfunction

	function automatic int block_units(int idx);
		return bba_pkg::MEM_UNITS >> level_of(idx);
	endfunction

	function automatic int block_base(int idx);
		int d = level_of(idx);
		return ((idx + 1) - (1 << d)) * block_units(idx);
	endfunction

	function automatic grant_t place_block(int req, logic [bba_pkg::OWNER_W-1:0] who);
		grant_t g = '{1'b0, '0, '0};
		int best = 0;
		int best_units = 0;
		bit found = 0;
		int idx;
		int units;
		if (req == 0)
			return g;
		for (idx = 0; idx < bba_pkg::NODE_COUNT; idx++) begin
			if (tree_kind[idx] == bba_pkg::KIND_FREE) begin
				units = block_units(idx);
				if (units >= req && (!found || units < best_units)) begin
					found = 1;
					best = idx;
					best_units = units;
				end
			end
		end
		if (!found)
			return g;
		idx = best;
		while (2 * idx + 2 < bba_pkg::NODE_COUNT && block_units(idx) / 2 >= req &&
				block_units(idx) / 2 >= bba_pkg::MIN_BLOCK) begin
			tree_kind[idx] = bba_pkg::KIND_SPLIT;
			tree_kind[2 * idx + 1] = bba_pkg::KIND_FREE;
			tree_kind[2 * idx + 2] = bba_pkg::KIND_FREE;
			idx = 2 * idx + 1;
		end
		tree_kind[idx] = bba_pkg::KIND_USED;
		tree_owner[idx] = who;
		g.ok = 1'b1;
		g.sa = bba_pkg::ADDR_W'(block_base(idx));
		g.ea = bba_pkg::ADDR_W'(block_base(idx) + block_units(idx) - 1);
		return g;
	endfunction

	function automatic grant_t release_block(logic [bba_pkg::OWNER_W-1:0] who);
		grant_t g = '{1'b0, '0, '0};
		int hit = 0;
		int hit_base = 0;
		bit found = 0;
		int idx;
		int sib;
		for (idx = 0; idx < bba_pkg::NODE_COUNT; idx++) begin
			if (tree_kind[idx] == bba_pkg::KIND_USED && tree_owner[idx] == who) begin
				if (!found || block_base(idx) < hit_base) begin
					found = 1;
					hit = idx;
					hit_base = block_base(idx);
				end
			end
		end
		if (!found)
			return g;
		idx = hit;
		tree_kind[idx] = bba_pkg::KIND_FREE;
		while (idx > 0) begin
			sib = (idx & 1) ? idx + 1 : idx - 1;
			if (tree_kind[sib] != bba_pkg::KIND_FREE)
				break;
			tree_kind[idx] = bba_pkg::KIND_ABSENT;
			tree_kind[sib] = bba_pkg::KIND_ABSENT;
			idx = (idx - 1) / 2;
			tree_kind[idx] = bba_pkg::KIND_FREE;
		end
		g.ok = 1'b1;
		return g;
	endfunction

	function automatic grant_t predict(request_t r);
		if (r.op == bba_pkg::OP_ALLOC)
			return place_block(int'(r.size), r.owner);
		return release_block(r.owner);
	endfunction

	task automatic add(bba_pkg::op_t o, int sz, logic [bba_pkg::OWNER_W-1:0] who);
		pending.push_back('{o, bba_pkg::REQ_W'(sz), who, 1'b0});
		total_items++;
	endtask

	task automatic add_drain();
		pending.push_back('{bba_pkg::OP_ALLOC, '0, '0, 1'b1});
	endtask

	logic next_start;
	grant_t g_new;
	request_t r_new;

	always @(posedge clk) begin
		if (arst_n) begin
			next_start = start;
			if (start && !busy) begin
				g_new = predict(held);
				grants_due.push_back(g_new);
				issued++;
				if (!g_new.ok)
					refusals++;
				else if (held.op == bba_pkg::OP_ALLOC)
					allocs_placed++;
				else
					frees_done++;
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (gap > 0) begin
					gap--;
				end else if (pending.size() > 0) begin
					if (pending[0].drain) begin
						if (grants_due.size() == 0)
							void'(pending.pop_front());
					end else if (issued < total_items - CALM_TAIL &&
							$urandom_range(0, 7) == 0) begin
						gap = $urandom_range(1, 15);
					end else begin
						r_new = pending.pop_front();
						held <= r_new;
						op <= r_new.op;
						request_size <= r_new.size;
						owner_id <= r_new.owner;
						next_start = 1'b1;
					end
				end
			end
			start <= next_start;
		end
	end

	grant_t g_due;

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (grants_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ok=%0b start=%0d end=%0d",
						ok, start_addr, end_addr);
			end else begin
				g_due = grants_due.pop_front();
				if (ok !== g_due.ok || start_addr !== g_due.sa || end_addr !== g_due.ea) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected ok=%0b start=%0d end=%0d,",
							" got ok=%0b start=%0d end=%0d"},
							g_due.ok, g_due.sa, g_due.ea, ok, start_addr, end_addr);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int k;
		int sz;
		int dice;
		logic [bba_pkg::OWNER_W-1:0] who;
		for (k = 0; k < bba_pkg::NODE_COUNT; k++)
			tree_kind[k] = bba_pkg::KIND_ABSENT;
		tree_kind[0] = bba_pkg::KIND_FREE;
		for (k = 0; k < 16; k++)
			owner_pool[k] = bba_pkg::OWNER_W'($urandom);
		owner_pool[0] = '0;
		owner_pool[1] = '1;

		// Directed part: zero size, whole memory, no fit, unknown owner,
		// duplicate owners, field extremes and merging back to the root.
		add(bba_pkg::OP_ALLOC, 0, 16'h0001);
		add(bba_pkg::OP_FREE, 0, 16'h1234);
		add(bba_pkg::OP_ALLOC, 1024, 16'hFFFF);
		add(bba_pkg::OP_ALLOC, 1, 16'h0000);
		add(bba_pkg::OP_FREE, 2047, 16'hFFFF);
		add(bba_pkg::OP_ALLOC, 1023, 16'h0000);
		add(bba_pkg::OP_FREE, 0, 16'h0000);
		add(bba_pkg::OP_ALLOC, 513, 16'h0005);
		add(bba_pkg::OP_FREE, 0, 16'h0005);
		add(bba_pkg::OP_ALLOC, 1, 16'h0007);
		add(bba_pkg::OP_ALLOC, 3, 16'h0007);
		add(bba_pkg::OP_ALLOC, 1, 16'h0008);
		add(bba_pkg::OP_ALLOC, 512, 16'h0009);
		add(bba_pkg::OP_ALLOC, 300, 16'h000A);
		add(bba_pkg::OP_FREE, 0, 16'h0007);
		add(bba_pkg::OP_FREE, 0, 16'h0007);
		add(bba_pkg::OP_FREE, 0, 16'h0007);
		add(bba_pkg::OP_FREE, 0, 16'h0008);
		add(bba_pkg::OP_FREE, 0, 16'h0009);
		add(bba_pkg::OP_ALLOC, 2, 16'hAAAA);
		add(bba_pkg::OP_FREE, 0, 16'hAAAA);
		add_drain();

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			dice = $urandom_range(0, 99);
			who = ($urandom_range(0, 9) == 0) ? bba_pkg::OWNER_W'($urandom) :
				owner_pool[$urandom_range(0, 15)];
			if (dice < 52) begin
				if ($urandom_range(0, 29) == 0)
					sz = 0;
				else if ($urandom_range(0, 9) == 0)
					sz = $urandom_range(1, 1024);
				else
					sz = $urandom_range(1, 64);
				add(bba_pkg::OP_ALLOC, sz, who);
			end else begin
				add(bba_pkg::OP_FREE, $urandom_range(0, 2047), who);
			end
			if (k == RANDOM_ITEMS / 2)
				add_drain();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() > 0 || start || grants_due.size() > 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		$display("%0d transactions: %0d blocks placed, %0d blocks freed, %0d refused",
			issued, allocs_placed, frees_done, refusals);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && grants_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

>>> buddy_block_allocator.f
design/bba_pkg.sv
design/bba_ram.sv
design/buddy_block_allocator.sv
verif/buddy_block_allocator_test.sv
